/* rtl/pbc_pkg.sv */
package pbc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_CYL,
        ST_DIV_HEAD,
        ST_EMIT,
        ST_ERROR
    } pbc_state_t;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_CYL   = 2'd2;

    // configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PART0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECS  = 3'd5;

    // geometry limits and reset values
    localparam logic [4:0] HEADS_MAX   = 5'd16;
    localparam logic [4:0] HEADS_RESET = 5'd16;
    localparam logic [5:0] SECS_RESET  = 6'd63;

    // divider widths and step counts
    localparam int unsigned DIVD_W = 32;
    localparam int unsigned DIVS_W = 10;
    localparam int unsigned STEP_W = 6;
    localparam logic [STEP_W-1:0] CYL_STEPS  = 6'd32;
    localparam logic [STEP_W-1:0] HEAD_STEPS = 6'd10;

    localparam int unsigned RUN_W = 7;
    localparam int unsigned CYL_W = 16;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } pbc_div_req_t;

    // effective disk geometry
    typedef struct packed {
        logic [DIVS_W-1:0] per_cyl;
        logic [4:0]        heads;
        logic [5:0]        secs;
    } pbc_geom_t;

endpackage

/* rtl/pbc_cfg.sv */
module pbc_cfg
    import pbc_pkg::*;
#(
    parameter int PARTITIONS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [63:0]          wr_data,
    input  logic [1:0]           part_sel,
    output logic                 part_ok,
    output logic [31:0]          part_start,
    output logic [31:0]          part_length,
    output pbc_geom_t            geom
);

    logic [63:0] extent_reg [PARTITIONS];
    logic [4:0]  heads_reg;
    logic [5:0]  secs_reg;
    logic [4:0]  heads_eff;
    logic [5:0]  secs_eff;
    logic [10:0] per_cyl_full;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PARTITIONS; i++) begin
                extent_reg[i] <= '0;
            end
            heads_reg <= HEADS_RESET;
            secs_reg  <= SECS_RESET;
        end else if (wr_en) begin
            for (int i = 0; i < PARTITIONS; i++) begin
                if (wr_index == REG_PART0 + CFG_IDX_W'(i)) begin
                    extent_reg[i] <= wr_data;
                end
            end
            if (wr_index == REG_HEADS) begin
                heads_reg <= wr_data[4:0];
            end
            if (wr_index == REG_SECS) begin
                secs_reg <= wr_data[5:0];
            end
        end
    end

    // partition lookup
    always_comb begin
        part_ok     = 1'b0;
        part_start  = '0;
        part_length = '0;
        for (int i = 0; i < PARTITIONS; i++) begin
            if (part_sel == 2'(i)) begin
                part_ok     = 1'b1;
                part_start  = extent_reg[i][31:0];
                part_length = extent_reg[i][63:32];
            end
        end
    end

    // clamp degenerate geometry
    always_comb begin
        if (heads_reg == '0) begin
            heads_eff = 5'd1;
        end else if (heads_reg > HEADS_MAX) begin
            heads_eff = HEADS_MAX;
        end else begin
            heads_eff = heads_reg;
        end
        secs_eff     = (secs_reg == '0) ? 6'd1 : secs_reg;
        per_cyl_full = 11'(heads_eff) * 11'(secs_eff);
        geom.per_cyl = per_cyl_full[DIVS_W-1:0];
        geom.heads   = heads_eff;
        geom.secs    = secs_eff;
    end

endmodule

/* rtl/pbc_div.sv */
module pbc_div
    import pbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pbc_div_req_t      req,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient,
    output logic [DIVS_W-1:0] remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIVD_W-1:0] dq_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, dq_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, divisor held for the whole division
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/partition_block_to_chs_unit.sv */
// Translates a partition-relative block run into cylinder/head/sector results.
// A request is checked against the partition length, offset by the partition
// start, then divided once by heads*sectors and once by sectors on a shared
// one-bit-per-cycle divider; later blocks of the run are stepped by counting.
// An out-of-range request passes the check and error states to its range
// error result; an in-range one runs both divisions before its first block
// result, then one result per cycle while m_ready is high. s_ready is high
// only between requests. Register writes are taken at any time but are meant
// for idle periods.
module partition_block_to_chs_unit
    import pbc_pkg::*;
#(
    parameter int MAX_RUN    = 64,
    parameter int PARTITIONS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    // request
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_drive_number,
    input  logic [1:0]           s_partition_index,
    input  logic [31:0]          s_first_block,
    input  logic [RUN_W-1:0]     s_block_count,
    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_drive_out,
    output logic [CYL_W-1:0]     m_cylinder,
    output logic [3:0]           m_head,
    output logic [5:0]           m_sector,
    output logic [1:0]           m_status,
    output logic                 m_last
);

    localparam int RUN_CAP = (MAX_RUN < 64) ? MAX_RUN : 64;

    pbc_state_t state_reg, state_next;

    logic              drive_reg;
    logic [1:0]        part_reg;
    logic [31:0]       first_reg;
    logic [RUN_W-1:0]  remain_reg, remain_next;
    logic [CYL_W:0]    cyl_reg, cyl_next;
    logic [3:0]        head_reg, head_next;
    logic [5:0]        sec_reg, sec_next;
    logic [1:0]        err_reg, err_next;

    logic              m_valid_reg;
    logic              m_drive_reg;
    logic [CYL_W-1:0]  m_cyl_reg;
    logic [3:0]        m_head_reg;
    logic [5:0]        m_sec_reg;
    logic [1:0]        m_status_reg;
    logic              m_last_reg;

    logic              out_free;
    logic              out_load;
    logic [CYL_W-1:0]  out_cyl;
    logic [3:0]        out_head;
    logic [5:0]        out_sec;
    logic [1:0]        out_status;
    logic              out_last;

    logic              accept;
    logic [RUN_W-1:0]  count_eff;
    logic              part_ok;
    logic [31:0]       part_start;
    logic [31:0]       part_length;
    pbc_geom_t         geom;
    logic              in_range;
    logic              cyl_over;

    pbc_div_req_t      div_req;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quot;
    logic [DIVS_W-1:0] div_rem;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign count_eff = (s_block_count > RUN_W'(RUN_CAP)) ? RUN_W'(RUN_CAP) : s_block_count;
    assign in_range  = part_ok && (first_reg < part_length);
    assign cyl_over  = div_quot[DIVD_W-1:CYL_W] != '0;

    pbc_cfg #(
        .PARTITIONS (PARTITIONS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (cfg_valid && cfg_ready),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .part_sel    (part_reg),
        .part_ok     (part_ok),
        .part_start  (part_start),
        .part_length (part_length),
        .geom        (geom)
    );

    pbc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (remain_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (!in_range) begin
                    state_next = ST_ERROR;
                end else begin
                    state_next = ST_DIV_CYL;
                end
            end
            ST_DIV_CYL: begin
                if (div_done) begin
                    state_next = cyl_over ? ST_ERROR : ST_DIV_HEAD;
                end
            end
            ST_DIV_HEAD: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && (cyl_reg[CYL_W] || remain_reg == RUN_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERROR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        s_ready      = 1'b0;
        div_req      = '0;
        div_dividend = part_start + first_reg;
        div_divisor  = geom.per_cyl;
        out_load     = 1'b0;
        out_cyl      = '0;
        out_head     = '0;
        out_sec      = '0;
        out_status   = STATUS_OK;
        out_last     = 1'b1;
        remain_next  = remain_reg;
        cyl_next     = cyl_reg;
        head_next    = head_reg;
        sec_next     = sec_reg;
        err_next     = err_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    remain_next = count_eff;
                end
            end
            ST_CHECK: begin
                if (remain_reg != '0) begin
                    if (!in_range) begin
                        err_next = STATUS_RANGE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.steps = CYL_STEPS;
                    end
                end
            end
            ST_DIV_CYL: begin
                div_dividend = {div_rem, {(DIVD_W-DIVS_W){1'b0}}};
                div_divisor  = DIVS_W'(geom.secs);
                if (div_done) begin
                    if (cyl_over) begin
                        err_next = STATUS_CYL;
                    end else begin
                        cyl_next      = {1'b0, div_quot[CYL_W-1:0]};
                        div_req.start = 1'b1;
                        div_req.steps = HEAD_STEPS;
                    end
                end
            end
            ST_DIV_HEAD: begin
                if (div_done) begin
                    head_next = div_quot[3:0];
                    sec_next  = div_rem[5:0];
                end
            end
            ST_EMIT: begin
                out_load = out_free;
                if (cyl_reg[CYL_W]) begin
                    out_status = STATUS_CYL;
                end else begin
                    out_cyl  = cyl_reg[CYL_W-1:0];
                    out_head = head_reg;
                    out_sec  = sec_reg + 6'd1;
                    out_last = remain_reg == RUN_W'(1);
                end
                // step to the next block of the run
                if (out_free) begin
                    remain_next = remain_reg - 1'b1;
                    if (sec_reg == geom.secs - 6'd1) begin
                        sec_next = '0;
                        if ({1'b0, head_reg} == geom.heads - 5'd1) begin
                            head_next = '0;
                            cyl_next  = cyl_reg + 1'b1;
                        end else begin
                            head_next = head_reg + 4'd1;
                        end
                    end else begin
                        sec_next = sec_reg + 6'd1;
                    end
                end
            end
            ST_ERROR: begin
                out_load   = out_free;
                out_status = err_reg;
            end
            default: ;
        endcase
    end

    // sequencer and run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    // request capture and block position
    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg <= s_drive_number;
            part_reg  <= s_partition_index;
            first_reg <= s_first_block;
        end
        cyl_reg  <= cyl_next;
        head_reg <= head_next;
        sec_reg  <= sec_next;
        err_reg  <= err_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_drive_reg  <= drive_reg;
            m_cyl_reg    <= out_cyl;
            m_head_reg   <= out_head;
            m_sec_reg    <= out_sec;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive_out = m_drive_reg;
    assign m_cylinder  = m_cyl_reg;
    assign m_head      = m_head_reg;
    assign m_sector    = m_sec_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

endmodule

/* rtl/pbc_checker.sv */
module pbc_checker
    import pbc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_drive_out,
    input logic [CYL_W-1:0]     m_cylinder,
    input logic [3:0]           m_head,
    input logic [5:0]           m_sector,
    input logic [1:0]           m_status,
    input logic                 m_last
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_drive_out, m_cylinder, m_head,
            m_sector, m_status, m_last}))
    else $error("result changed while stalled");

    // an error result is zeroed and closes the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |->
            m_cylinder == '0 && m_head == '0 && m_sector == '0 && m_last)
    else $error("error result not zeroed or not last");

    // a good result carries a one-based sector
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OK |-> m_sector != '0)
    else $error("good result with sector zero");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
    else $error("request taken while previous one is in work");

endmodule

bind partition_block_to_chs_unit pbc_checker u_pbc_checker (.*);
